// File: rtl/ssd_pkg.sv
// Shared types and constants for the speech segment detector.
// No dependencies; used by the interfaces, the step logic and the top level.
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int PROB_W   = 16;
  localparam int PAD_W    = 16;
  localparam int SAMPLE_W = 32;

  // 0.15 and 0.01 in Q0.16, truncated
  localparam logic [PROB_W-1:0] HYST_Q16  = 16'd9830;
  localparam logic [PROB_W-1:0] FLOOR_Q16 = 16'd655;
  localparam logic [PROB_W-1:0] RELEASE_MIN_THR = 16'd10485;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_THRESHOLD   = 3'd0,
    REG_SPEECH_PAD  = 3'd1,
    REG_MIN_SPEECH  = 3'd2,
    REG_MIN_SILENCE = 3'd3,
    REG_MAX_SPEECH  = 3'd4
  } cfg_reg_t;

  // input item kinds
  localparam logic KIND_CHUNK = 1'b0;
  localparam logic KIND_EOS   = 1'b1;

  typedef struct packed {
    logic [PROB_W-1:0]   threshold;
    logic [PAD_W-1:0]    pad_len;
    logic [SAMPLE_W-1:0] min_seg_len;
    logic [SAMPLE_W-1:0] min_quiet_len;
    logic [SAMPLE_W-1:0] max_seg_len;
  } cfg_t;

  typedef struct packed {
    logic                in_speech;
    logic [SAMPLE_W-1:0] segment_start;
    logic [SAMPLE_W-1:0] tentative_end;
    logic [SAMPLE_W-1:0] chunk_position;
  } seg_state_t;

endpackage

// File: rtl/ssd_in_if.sv
// Input channel of the speech segment detector: valid/ready plus one item.
// Depends on ssd_pkg for field widths.
`timescale 1ns / 1ps

interface ssd_in_if import ssd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [PROB_W-1:0]   probability;
  logic [SAMPLE_W-1:0] total_samples;

  modport source (output valid, output kind, output probability, output total_samples,
                  input ready);
  modport sink   (input valid, input kind, input probability, input total_samples,
                  output ready);
endinterface

// File: rtl/ssd_out_if.sv
// Result channel of the speech segment detector: valid/ready plus one segment.
// Depends on ssd_pkg for field widths.
`timescale 1ns / 1ps

interface ssd_out_if import ssd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] start_sample;
  logic [SAMPLE_W-1:0] stop_sample;

  modport source (output valid, output start_sample, output stop_sample, input ready);
  modport sink   (input valid, input start_sample, input stop_sample, output ready);
endinterface

// File: rtl/speech_segment_detector_unit.sv
// Top level of the speech segment detector: configuration registers, input
// register, segment state and result register. Depends on ssd_pkg,
// ssd_in_if, ssd_out_if and ssd_seg_step.
//
// Usage:
//   in_ch carries one item per chunk of CHUNK_SAMPLES samples (kind 0, a
//   Q0.16 speech probability) or an end-of-stream item (kind 1, the total
//   length in samples) that closes open speech and rewinds the position.
//   out_ch carries zero or one segment (start, end) per item.
//   cfg_we/cfg_index/cfg_data write a register; write only
//   while no item is in flight.
// Timing:
//   An accepted item sits in the input register; its result, if any, is
//   registered as the item leaves it and is then offered on out_ch. One
//   item per cycle is sustained while out_ch does not hold back a result: the
//   state update and the segment decision are one pass of compare/add logic.
// Reset (rst_n low, synchronous): registers take their defaults, the
//   stream position and speech state clear, both channels go empty.
// Stall: while a result waits on out_ch, one further item is held in the
//   input register; in_ch.ready then drops until the result is taken.
`timescale 1ns / 1ps

module speech_segment_detector_unit import ssd_pkg::*; #(
  parameter int CHUNK_SAMPLES = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  ssd_in_if.sink              in_ch,
  ssd_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  cfg_t                cfg_r;
  seg_state_t          st_r;
  seg_state_t          st_nxt;
  logic                s1_valid_r;
  logic                s1_kind_r;
  logic [PROB_W-1:0]   s1_prob_r;
  logic [SAMPLE_W-1:0] s1_total_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_start_r;
  logic [SAMPLE_W-1:0] out_stop_r;
  logic                advance;
  logic                in_take;
  logic                res_valid;
  logic [SAMPLE_W-1:0] res_start;
  logic [SAMPLE_W-1:0] res_end;

  // the staged item moves on when the result register is free or being emptied
  assign advance = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.start_sample = out_start_r;
  assign out_ch.stop_sample  = out_stop_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold     <= 16'd32768;
      cfg_r.pad_len       <= 16'd480;
      cfg_r.min_seg_len   <= 32'd4000;
      cfg_r.min_quiet_len <= 32'd1600;
      cfg_r.max_seg_len   <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD:   cfg_r.threshold     <= cfg_data[PROB_W-1:0];
        REG_SPEECH_PAD:  cfg_r.pad_len       <= cfg_data[PAD_W-1:0];
        REG_MIN_SPEECH:  cfg_r.min_seg_len   <= cfg_data;
        REG_MIN_SILENCE: cfg_r.min_quiet_len <= cfg_data;
        REG_MAX_SPEECH:  cfg_r.max_seg_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r  <= in_ch.kind;
      s1_prob_r  <= in_ch.probability;
      s1_total_r <= in_ch.total_samples;
    end
  end

  ssd_seg_step #(
    .CHUNK_SAMPLES (CHUNK_SAMPLES)
  ) u_step (
    .cfg           (cfg_r),
    .st            (st_r),
    .kind          (s1_kind_r),
    .probability   (s1_prob_r),
    .total_samples (s1_total_r),
    .st_nxt        (st_nxt),
    .res_valid     (res_valid),
    .res_start     (res_start),
    .res_end       (res_end)
  );

  // segment state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_start_r <= res_start;
      out_stop_r  <= res_end;
    end
  end

  // a new result only comes from an item that just left the input register
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result appeared without a processed item");

  // a segment is only emitted out of speech
  a_emit_in_speech: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |-> st_r.in_speech)
    else $error("segment emitted while not in speech");

  // no pending end outside speech
  a_no_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.in_speech |-> (st_r.tentative_end == '0))
    else $error("tentative end held outside speech");

  // end of stream rewinds the stream
  a_eos_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_kind_r == KIND_EOS)) |=> (st_r == '0))
    else $error("stream state not cleared after end of stream");

endmodule

// File: rtl/ssd_seg_step.sv
// Combinational segment decision for one item: hysteresis, silence timing,
// padding, minimum length and length limit. Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_seg_step import ssd_pkg::*; #(
  parameter int CHUNK_SAMPLES = 512
) (
  input  cfg_t                cfg,
  input  seg_state_t          st,
  input  logic                kind,
  input  logic [PROB_W-1:0]   probability,
  input  logic [SAMPLE_W-1:0] total_samples,
  output seg_state_t          st_nxt,
  output logic                res_valid,
  output logic [SAMPLE_W-1:0] res_start,
  output logic [SAMPLE_W-1:0] res_end
);

  localparam logic [SAMPLE_W:0]   CHUNK_W1 = (SAMPLE_W+1)'(CHUNK_SAMPLES);
  localparam logic [SAMPLE_W+1:0] CHUNK_W2 = (SAMPLE_W+2)'(CHUNK_SAMPLES);

  logic [PROB_W-1:0]   release_lvl;
  logic                trig;
  logic                low;
  logic [SAMPLE_W:0]   chunk_end;
  logic [SAMPLE_W-1:0] start_new;
  logic [SAMPLE_W-1:0] te_kept;
  logic [SAMPLE_W-1:0] te_set;
  logic [SAMPLE_W+1:0] silence;
  logic                silence_ok;
  logic [SAMPLE_W:0]   end_pad;
  logic [SAMPLE_W+1:0] seg_len;
  logic                len_ok;
  logic [SAMPLE_W+1:0] limit;
  logic                limit_on;
  logic [SAMPLE_W:0]   start_lim;
  logic [SAMPLE_W:0]   close_end;
  logic [SAMPLE_W-1:0] eos_end;

  // release level and hysteresis compares
  assign release_lvl = (cfg.threshold >= RELEASE_MIN_THR) ? cfg.threshold - HYST_Q16
                                                          : FLOOR_Q16;
  assign trig = (probability >= cfg.threshold);
  assign low  = (probability < release_lvl);

  // chunk bounds, exact (not wrapped)
  assign chunk_end = {1'b0, st.chunk_position} + CHUNK_W1;
  assign start_new = (st.chunk_position > {{(SAMPLE_W-PAD_W){1'b0}}, cfg.pad_len})
                   ? st.chunk_position - {{(SAMPLE_W-PAD_W){1'b0}}, cfg.pad_len}
                   : '0;

  // tentative end: cleared by speech, set on first quiet chunk
  assign te_kept = trig ? '0 : st.tentative_end;
  assign te_set  = (te_kept == '0) ? chunk_end[SAMPLE_W-1:0] : te_kept;

  // silence duration, signed so a wrapped end never closes
  assign silence    = {1'b0, chunk_end} - {2'b00, te_set};
  assign silence_ok = (te_set != '0) && !silence[SAMPLE_W+1] &&
                      (silence[SAMPLE_W:0] >= {1'b0, cfg.min_quiet_len});

  // padded end and segment length
  assign end_pad = {1'b0, te_set} + {{(SAMPLE_W+1-PAD_W){1'b0}}, cfg.pad_len};
  assign seg_len = {1'b0, end_pad} - {2'b00, st.segment_start};
  assign len_ok  = !seg_len[SAMPLE_W+1] && (seg_len[SAMPLE_W:0] >= {1'b0, cfg.min_seg_len});

  // length limit, active only when positive
  assign limit = {2'b00, cfg.max_seg_len} - CHUNK_W2
               - {{(SAMPLE_W+1-PAD_W){1'b0}}, cfg.pad_len, 1'b0};
  assign limit_on  = !limit[SAMPLE_W+1] && (limit != '0);
  assign start_lim = {1'b0, st.segment_start} + {1'b0, limit[SAMPLE_W-1:0]};

  assign close_end = (limit_on && ($signed(seg_len) > $signed(limit))) ? start_lim : end_pad;
  assign eos_end   = (limit_on && (start_lim < {1'b0, total_samples}))
                   ? start_lim[SAMPLE_W-1:0] : total_samples;

  // decide next state and result
  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    res_start = st.segment_start;
    res_end   = eos_end;
    if (kind == KIND_EOS) begin
      res_valid = st.in_speech;
      st_nxt    = '0;
    end else begin
      st_nxt.tentative_end  = te_kept;
      st_nxt.chunk_position = chunk_end[SAMPLE_W-1:0];
      if (trig && !st.in_speech) begin
        st_nxt.in_speech     = 1'b1;
        st_nxt.segment_start = start_new;
      end else if (low && st.in_speech) begin
        st_nxt.tentative_end = te_set;
        if (silence_ok) begin
          res_valid            = len_ok;
          res_end              = close_end[SAMPLE_W] ? '1 : close_end[SAMPLE_W-1:0];
          st_nxt.in_speech     = 1'b0;
          st_nxt.tentative_end = '0;
        end
      end
    end
  end

endmodule
